### rtl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// shared types, widths, constants and the t sample table of the easing block
// ----------------------------------------------------------------------------
package cbe_pkg;

   localparam int TABLE_SIZE   = 11;
   localparam int NEWTON_STEPS = 4;
   localparam int BISECT_STEPS = 10;

   localparam int IDX_W     = $clog2(TABLE_SIZE);
   localparam int MAX_STEPS = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
   localparam int ITER_W    = $clog2(MAX_STEPS + 1);

   // field widths
   localparam int X_W  = 18;   // progress
   localparam int CX_W = 17;   // control x
   localparam int CY_W = 20;   // control y
   localparam int Y_W  = 20;   // eased value
   localparam int S_W  = 20;   // table samples
   localparam int T_W  = 18;   // curve parameter t, signed, 0..65536

   // datapath widths
   localparam int CO_W   = 28;            // coefficients and partial sums
   localparam int PROD_W = CO_W + T_W;    // multiplier product
   localparam int DIV_W  = 40;            // dividend magnitude
   localparam int DEN_W  = 24;            // divisor magnitude
   localparam int DCNT_W = $clog2(DIV_W);

   // port widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_ADDR_W-1:0] CSR_CTRL1_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CTRL1_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CTRL2_X = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CTRL2_Y = 2'd3;

   localparam logic signed [T_W-1:0]  ONE_Q16   = 18'sd65536;
   localparam logic [CX_W-1:0]        ONE_X     = 17'd65536;
   localparam logic signed [CO_W-1:0] ONE_CO    = 28'sd65536;
   localparam logic signed [CO_W-1:0] MIN_SLOPE = 28'sd66;
   localparam logic signed [CO_W-1:0] Y_MAX     = 28'sd524287;
   localparam logic signed [CO_W-1:0] Y_MIN     = -28'sd524288;

   typedef logic [TABLE_SIZE-1:0][T_W-1:0] t_table_type;

   // t_i = round(i / (TABLE_SIZE-1)) in Q16
   function automatic t_table_type calc_t_table();
      t_table_type tab;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         tab[i] = T_W'((i * 65536 + (TABLE_SIZE - 1) / 2) / (TABLE_SIZE - 1));
      end
      return tab;
   endfunction

   localparam t_table_type T_TABLE = calc_t_table();

   typedef struct packed {
      logic signed [CO_W-1:0] a;
      logic signed [CO_W-1:0] a3;
      logic signed [CO_W-1:0] b;
      logic signed [CO_W-1:0] b2;
      logic signed [CO_W-1:0] c;
   } coef_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PREP,
      S_BUILD,
      S_BUILD_WR,
      S_SCAN,
      S_GUESS_MUL,
      S_GUESS_PROD,
      S_GUESS_FIN,
      S_SLOPE_CHK,
      S_NT_DIV,
      S_NT_UPD,
      S_NT_SLOPE,
      S_BS_MID,
      S_BS_UPD,
      S_FINAL,
      S_FIN_WR,
      S_EVAL,
      S_DIV,
      S_OUT
   } state_type;

endpackage

### rtl/cubic_bezier_easing.sv
// ----------------------------------------------------------------------------
// cubic_bezier_easing
// cubic bezier easing curve, end points (0,0) and (1,1), Q16 fixed point
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  req     | in        | req_tvalid/tready    | progress, signed Q16
//  rsp     | out       | rsp_tvalid/tready    | eased_value, signed Q16
//  csr     | in        | csr_wr_en, no wait   | ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
//
//  one transaction at a time; the linear case and progress at or beyond 0 or 1
//  go straight to the output state, while a solved point runs the table scan
//  and the bit-serial divider, one division per newton step plus one for the
//  guess
//  after reset and after each csr write the x sample table is rebuilt, with
//  req_tready low meanwhile
//  the result sits in an output register, so a new transaction is taken while
//  the last result still waits for rsp_tready
//
module cubic_bezier_easing (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [17:0] progress, rest zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cbe_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata: [19:0] eased_value, rest zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cbe_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [cbe_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [cbe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cbe_pkg::*;

   // ------------------------------------------------------------------------
   // declarations
   // ------------------------------------------------------------------------
   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   logic [CX_W-1:0]        c1x_ff, c2x_ff;
   logic signed [CY_W-1:0] c1y_ff, c2y_ff;
   coef_type               coef_x_ff, coef_y_ff, coef_sel;
   logic                   lin_ff;

   logic signed [S_W-1:0]  tbl_ff [TABLE_SIZE];
   logic signed [S_W-1:0]  tbl_rd;

   logic [IDX_W-1:0]       idx_ff, idx_in, k_ff, k_in, k_nxt;
   logic signed [X_W-1:0]  x_ff, x_in, prog;
   logic signed [T_W-1:0]  t_ff, t_in, g_ff, g_in, a_ff, a_in, b_ff, b_in;
   logic signed [S_W-1:0]  s_lo_ff, s_lo_in, s_hi_ff, s_hi_in;
   logic signed [CO_W-1:0] sl_ff, sl_in;
   logic [ITER_W-1:0]      it_ff, it_in;

   logic [1:0]             ev_cnt_ff, ev_cnt_in;
   logic                   ev_slope_ff, ev_slope_in, ev_ysel_ff, ev_ysel_in;
   logic signed [CO_W-1:0] ev_res_ff, ev_res_in;

   logic signed [PROD_W-1:0] prod_ff, prod_rnd;
   logic signed [CO_W-1:0]   mul_a, rnd_co, h_next;
   logic signed [T_W-1:0]    mul_b;

   logic [DEN_W:0]         div_rem_ff;
   logic [DIV_W-1:0]       div_quo_ff;
   logic [DEN_W-1:0]       div_den_ff;
   logic                   div_neg_ff;
   logic [DCNT_W-1:0]      div_cnt_ff;
   logic [DEN_W:0]         div_trial;
   logic                   div_start;
   logic signed [DIV_W:0]  div_num, div_abs_num;
   logic signed [DEN_W:0]  div_den, div_abs_den;
   logic signed [DIV_W:0]  div_q;

   logic signed [Y_W-1:0]  res_ff, res_in;
   logic                   rsp_valid_ff;
   logic [Y_W-1:0]         rsp_data_ff;

   logic                   req_fire, out_free, ev_last, div_last;
   logic                   scan_stop, flat, nt_done, bs_done, special;
   logic signed [CO_W:0]   resid;
   logic signed [T_W:0]    bs_diff;
   logic signed [T_W-1:0]  bs_mid, g_guess, g_newton;
   logic signed [Y_W-1:0]  y_sat;

   // ------------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------------
   function automatic coef_type calc_coef(input logic signed [CY_W:0] a1,
                                          input logic signed [CY_W:0] a2);
      coef_type               cf;
      logic signed [CO_W-1:0] a13, a23;
      a13   = CO_W'(a1) + (CO_W'(a1) <<< 1);
      a23   = CO_W'(a2) + (CO_W'(a2) <<< 1);
      cf.a  = ONE_CO - a23 + a13;
      cf.a3 = cf.a + (cf.a <<< 1);
      cf.b  = a23 - (a13 <<< 1);
      cf.b2 = cf.b <<< 1;
      cf.c  = a13;
      return cf;
   endfunction

   // clamp to the t range 0..1
   function automatic logic signed [T_W-1:0] clamp_t(input logic signed [DIV_W+1:0] v);
      logic signed [T_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > (DIV_W+2)'(ONE_Q16)) begin
         r = ONE_Q16;
      end else begin
         r = v[T_W-1:0];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // configuration registers and derived coefficients
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         c1x_ff <= '0;
         c1y_ff <= '0;
         c2x_ff <= ONE_X;
         c2y_ff <= CY_W'(ONE_CO);
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_CTRL1_X: begin
               c1x_ff <= (csr_wdata[CX_W-1:0] > ONE_X) ? ONE_X : csr_wdata[CX_W-1:0];
            end
            CSR_CTRL1_Y: begin
               c1y_ff <= $signed(csr_wdata[CY_W-1:0]);
            end
            CSR_CTRL2_X: begin
               c2x_ff <= (csr_wdata[CX_W-1:0] > ONE_X) ? ONE_X : csr_wdata[CX_W-1:0];
            end
            CSR_CTRL2_Y: begin
               c2y_ff <= $signed(csr_wdata[CY_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // coefficients follow the registers in the next cycle, covered by S_PREP
   always_ff @(posedge clock) begin
      coef_x_ff <= calc_coef($signed({4'b0000, c1x_ff}), $signed({4'b0000, c2x_ff}));
      coef_y_ff <= calc_coef((CY_W+1)'(c1y_ff), (CY_W+1)'(c2y_ff));
      lin_ff    <= ($signed({4'b0000, c1x_ff}) == (CY_W+1)'(c1y_ff)) &&
                   ($signed({4'b0000, c2x_ff}) == (CY_W+1)'(c2y_ff));
   end

   // ------------------------------------------------------------------------
   // shared multiplier and the bezier / slope evaluation terms
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // round half up back to Q16
   assign prod_rnd = (prod_ff + $signed(PROD_W'(32768))) >>> 16;
   assign rnd_co   = prod_rnd[CO_W-1:0];
   assign coef_sel = ev_ysel_ff ? coef_y_ff : coef_x_ff;
   assign h_next   = (ev_cnt_ff == 2'd1) ? rnd_co + (ev_slope_ff ? coef_sel.b2 : coef_sel.b)
                                         : rnd_co + coef_sel.c;

   // ------------------------------------------------------------------------
   // bit-serial restoring divider, truncates toward zero
   // ------------------------------------------------------------------------
   assign div_abs_num = div_num[DIV_W] ? -div_num : div_num;
   assign div_abs_den = div_den[DEN_W] ? -div_den : div_den;
   assign div_trial   = {div_rem_ff[DEN_W-1:0], div_quo_ff[DIV_W-1]} - {1'b0, div_den_ff};
   assign div_q       = div_neg_ff ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});

   always_ff @(posedge clock) begin
      if (div_start) begin
         div_rem_ff <= '0;
         div_quo_ff <= div_abs_num[DIV_W-1:0];
         div_den_ff <= div_abs_den[DEN_W-1:0];
         div_neg_ff <= div_num[DIV_W] ^ div_den[DEN_W];
         div_cnt_ff <= '0;
      end else if (state_ff == S_DIV) begin
         if (!div_trial[DEN_W]) begin
            div_rem_ff <= div_trial;
            div_quo_ff <= {div_quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            div_rem_ff <= {div_rem_ff[DEN_W-1:0], div_quo_ff[DIV_W-1]};
            div_quo_ff <= {div_quo_ff[DIV_W-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // x sample table, written during the rebuild sweep
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == S_BUILD_WR) begin
         tbl_ff[idx_ff] <= ev_res_ff[S_W-1:0];
      end
   end

   assign tbl_rd = tbl_ff[idx_ff];

   // ------------------------------------------------------------------------
   // decision terms
   // ------------------------------------------------------------------------
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign prog       = $signed(req_tdata[X_W-1:0]);
   assign special    = lin_ff || (prog <= 0) || (prog >= X_W'(ONE_Q16));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ev_last    = ev_slope_ff ? (ev_cnt_ff == 2'd2) : (ev_cnt_ff == 2'd3);
   assign div_last   = (div_cnt_ff == DCNT_W'(DIV_W - 1));
   // scan ends at the first sample above x, or at the last entry
   assign scan_stop  = (idx_ff != '0) &&
                       ((idx_ff == IDX_W'(TABLE_SIZE - 1)) || (tbl_rd > S_W'(x_ff)));
   assign flat       = (s_hi_ff == s_lo_ff);
   assign k_nxt      = IDX_W'(k_ff + 1'b1);
   assign resid      = (CO_W+1)'(ev_res_ff) - (CO_W+1)'(x_ff);
   assign nt_done    = (it_ff == ITER_W'(NEWTON_STEPS - 1));
   assign bs_done    = (resid == '0) || (it_ff == ITER_W'(BISECT_STEPS - 1));
   assign bs_diff    = (T_W+1)'(b_ff) - (T_W+1)'(a_ff);
   assign bs_mid     = a_ff + T_W'(bs_diff >>> 1);
   assign g_guess    = clamp_t($signed((DIV_W+2)'(T_TABLE[k_ff])) + (DIV_W+2)'(div_q));
   assign g_newton   = clamp_t((DIV_W+2)'(g_ff) - (DIV_W+2)'(div_q));
   assign y_sat      = (ev_res_ff > Y_MAX) ? Y_W'(Y_MAX) :
                       (ev_res_ff < Y_MIN) ? Y_W'(Y_MIN) : ev_res_ff[Y_W-1:0];

   // ------------------------------------------------------------------------
   // sequencer: next state and return point
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = special ? S_OUT : S_SCAN;
            end
         end
         S_PREP: begin
            state_in = S_BUILD;
         end
         S_BUILD: begin
            state_in = S_EVAL;
            ret_in   = S_BUILD_WR;
         end
         S_BUILD_WR: begin
            state_in = (idx_ff == IDX_W'(TABLE_SIZE - 1)) ? S_IDLE : S_BUILD;
         end
         S_SCAN: begin
            if (scan_stop) begin
               state_in = S_GUESS_MUL;
            end
         end
         S_GUESS_MUL: begin
            if (flat) begin
               state_in = S_EVAL;
               ret_in   = S_SLOPE_CHK;
            end else begin
               state_in = S_GUESS_PROD;
            end
         end
         S_GUESS_PROD: begin
            state_in = S_DIV;
            ret_in   = S_GUESS_FIN;
         end
         S_GUESS_FIN: begin
            state_in = S_EVAL;
            ret_in   = S_SLOPE_CHK;
         end
         S_SLOPE_CHK: begin
            priority if (ev_res_ff >= MIN_SLOPE) begin
               state_in = S_EVAL;
               ret_in   = S_NT_DIV;
            end else if (ev_res_ff == '0) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_BS_MID;
            end
         end
         S_NT_DIV: begin
            state_in = S_DIV;
            ret_in   = S_NT_UPD;
         end
         S_NT_UPD: begin
            if (nt_done) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_EVAL;
               ret_in   = S_NT_SLOPE;
            end
         end
         S_NT_SLOPE: begin
            if (ev_res_ff == '0) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_EVAL;
               ret_in   = S_NT_DIV;
            end
         end
         S_BS_MID: begin
            state_in = S_EVAL;
            ret_in   = S_BS_UPD;
         end
         S_BS_UPD: begin
            state_in = bs_done ? S_FINAL : S_BS_MID;
         end
         S_FINAL: begin
            state_in = S_EVAL;
            ret_in   = S_FIN_WR;
         end
         S_FIN_WR: begin
            state_in = S_OUT;
         end
         S_EVAL: begin
            if (ev_last) begin
               state_in = ret_ff;
            end
         end
         S_DIV: begin
            if (div_last) begin
               state_in = ret_ff;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a csr write always restarts the table rebuild
      if (csr_wr_en) begin
         state_in = S_PREP;
      end
   end

   // ------------------------------------------------------------------------
   // sequencer: datapath controls
   // ------------------------------------------------------------------------
   always_comb begin
      idx_in      = idx_ff;
      k_in        = k_ff;
      x_in        = x_ff;
      t_in        = t_ff;
      g_in        = g_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      s_lo_in     = s_lo_ff;
      s_hi_in     = s_hi_ff;
      sl_in       = sl_ff;
      it_in       = it_ff;
      ev_cnt_in   = '0;
      ev_slope_in = ev_slope_ff;
      ev_ysel_in  = ev_ysel_ff;
      ev_res_in   = ev_res_ff;
      res_in      = res_ff;
      mul_a       = '0;
      mul_b       = t_ff;
      div_start   = 1'b0;
      div_num     = '0;
      div_den     = '0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            x_in   = prog;
            priority if (lin_ff) begin
               res_in = Y_W'(prog);
            end else if (prog <= 0) begin
               res_in = '0;
            end else begin
               res_in = Y_W'(ONE_Q16);
            end
         end
         S_PREP: begin
            idx_in = '0;
         end
         S_BUILD: begin
            t_in        = $signed(T_TABLE[idx_ff]);
            ev_slope_in = 1'b0;
            ev_ysel_in  = 1'b0;
         end
         S_BUILD_WR: begin
            idx_in = IDX_W'(idx_ff + 1'b1);
         end
         S_SCAN: begin
            if (scan_stop) begin
               s_hi_in = tbl_rd;
               k_in    = IDX_W'(idx_ff - 1'b1);
            end else begin
               s_lo_in = tbl_rd;
               idx_in  = IDX_W'(idx_ff + 1'b1);
            end
         end
         S_GUESS_MUL: begin
            // flat interval: the guess is the interval start
            g_in        = $signed(T_TABLE[k_ff]);
            t_in        = $signed(T_TABLE[k_ff]);
            ev_slope_in = 1'b1;
            ev_ysel_in  = 1'b0;
            mul_a       = CO_W'(x_ff) - CO_W'(s_lo_ff);
            mul_b       = $signed(T_TABLE[k_nxt] - T_TABLE[k_ff]);
         end
         S_GUESS_PROD: begin
            div_start = 1'b1;
            div_num   = prod_ff[DIV_W:0];
            div_den   = (DEN_W+1)'(s_hi_ff) - (DEN_W+1)'(s_lo_ff);
         end
         S_GUESS_FIN: begin
            g_in        = g_guess;
            t_in        = g_guess;
            ev_slope_in = 1'b1;
            ev_ysel_in  = 1'b0;
         end
         S_SLOPE_CHK: begin
            sl_in       = ev_res_ff;
            it_in       = '0;
            a_in        = $signed(T_TABLE[k_ff]);
            b_in        = $signed(T_TABLE[k_nxt]);
            ev_slope_in = 1'b0;
            ev_ysel_in  = 1'b0;
         end
         S_NT_DIV: begin
            div_start = 1'b1;
            div_num   = (DIV_W+1)'(resid) <<< 16;
            div_den   = (DEN_W+1)'(sl_ff);
         end
         S_NT_UPD: begin
            g_in        = g_newton;
            t_in        = g_newton;
            it_in       = ITER_W'(it_ff + 1'b1);
            ev_slope_in = 1'b1;
            ev_ysel_in  = 1'b0;
         end
         S_NT_SLOPE: begin
            sl_in       = ev_res_ff;
            ev_slope_in = 1'b0;
            ev_ysel_in  = 1'b0;
         end
         S_BS_MID: begin
            t_in        = bs_mid;
            ev_slope_in = 1'b0;
            ev_ysel_in  = 1'b0;
         end
         S_BS_UPD: begin
            it_in = ITER_W'(it_ff + 1'b1);
            if (resid > 0) begin
               b_in = t_ff;
            end else begin
               a_in = t_ff;
            end
         end
         S_FINAL: begin
            ev_slope_in = 1'b0;
            ev_ysel_in  = 1'b1;
         end
         S_FIN_WR: begin
            res_in = y_sat;
         end
         S_EVAL: begin
            ev_cnt_in = ev_cnt_ff + 1'b1;
            unique case (ev_cnt_ff)
               2'd0: begin
                  mul_a = ev_slope_ff ? coef_sel.a3 : coef_sel.a;
               end
               2'd1: begin
                  mul_a = h_next;
               end
               2'd2: begin
                  mul_a     = h_next;
                  ev_res_in = h_next;
               end
               2'd3: begin
                  ev_res_in = rnd_co;
               end
               default: begin
               end
            endcase
         end
         S_DIV: begin
         end
         S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_PREP;
         ret_ff    <= S_IDLE;
         ev_cnt_ff <= '0;
         it_ff     <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         ev_cnt_ff <= ev_cnt_in;
         it_ff     <= it_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      x_ff        <= x_in;
      t_ff        <= t_in;
      g_ff        <= g_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      s_lo_ff     <= s_lo_in;
      s_hi_ff     <= s_hi_in;
      sl_ff       <= sl_in;
      ev_slope_ff <= ev_slope_in;
      ev_ysel_ff  <= ev_ysel_in;
      ev_res_ff   <= ev_res_in;
      res_ff      <= res_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - Y_W)'(0), rsp_data_ff};

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_den_ff != '0))
      else $error("divider started with a zero divisor");

   a_final_t_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL) |-> ((t_ff >= 0) && (t_ff <= ONE_Q16)))
      else $error("solved t outside 0..1");

   a_bisect_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BS_MID) |-> (a_ff <= b_ff))
      else $error("bisection bracket inverted");

   a_csr_rebuild : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (state_ff == S_PREP))
      else $error("csr write did not restart the table rebuild");

endmodule

### bench/cubic_bezier_easing_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_easing_tb
// stream bench for the cubic bezier easing block: a queue-fed driver offers
// progress values, a clocked monitor checks each eased value against a local
// fixed-point curve solver, across control point settings and idle patterns
// ----------------------------------------------------------------------------
module cubic_bezier_easing_tb;
   import cbe_pkg::*;

   localparam int NSAMP = 11;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [17:0] progress, rest zero
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [19:0] eased_value, rest zero
   logic csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cubic_bezier_easing u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------------
   // curve solver state, a mirror of the control registers
   // ---------------------------------------------------------------------
   longint p1x, p1y, p2x, p2y;
   longint x_samples [NSAMP];
   bit     is_linear;

   logic [X_W-1:0] progress_q [$];   // progress values waiting to be offered
   logic [Y_W-1:0] eased_q [$];      // eased values still owed by the block
   int  n_errors;
   int  n_eased;
   int  n_queued;
   int  n_configs;
   bit  req_taken;
   int  send_idle_pct;
   int  stall_pct;
   int  hold_cycles;

   function automatic longint rnd16(longint v);
      return (v + 32768) >>> 16;   // arithmetic shift floors
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint curve_at(longint t, longint a1, longint a2);
      longint ca, cb, cc, h;
      ca = 65536 - 3 * a2 + 3 * a1;
      cb = 3 * a2 - 6 * a1;
      cc = 3 * a1;
      h = rnd16(ca * t) + cb;
      h = rnd16(h * t) + cc;
      return rnd16(h * t);
   endfunction

   function automatic longint slope_x(longint t);
      longint ca, cb, cc, h;
      ca = 65536 - 3 * p2x + 3 * p1x;
      cb = 3 * p2x - 6 * p1x;
      cc = 3 * p1x;
      h = rnd16(3 * ca * t) + 2 * cb;
      return rnd16(h * t) + cc;
   endfunction

   function automatic longint sample_t(int i);
      return (longint'(i) * 65536 + (NSAMP - 1) / 2) / (NSAMP - 1);
   endfunction

   function automatic void refresh_curve();
      is_linear = (p1x == p1y) && (p2x == p2y);
      for (int i = 0; i < NSAMP; i++) x_samples[i] = curve_at(sample_t(i), p1x, p2x);
   endfunction

   function automatic void apply_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      case (idx)
         CSR_CTRL1_X: p1x = clip(longint'(v[CX_W-1:0]), 0, 65536);
         CSR_CTRL1_Y: p1y = longint'($signed(v[CY_W-1:0]));
         CSR_CTRL2_X: p2x = clip(longint'(v[CX_W-1:0]), 0, 65536);
         CSR_CTRL2_Y: p2y = longint'($signed(v[CY_W-1:0]));
         default: ;
      endcase
      refresh_curve();
   endfunction

   // find t with x(t) == x: table scan, interpolated guess, newton or bisection
   function automatic longint find_t(longint x);
      int k;
      longint t0, t1, s0, s1, g, sl, s, r, lo, hi, mid;
      k = 1;
      while (k != NSAMP - 1 && x_samples[k] <= x) k++;
      k--;
      t0 = sample_t(k);
      t1 = sample_t(k + 1);
      s0 = x_samples[k];
      s1 = x_samples[k + 1];
      // flat interval keeps the left sample
      g = (s1 != s0) ? t0 + ((x - s0) * (t1 - t0)) / (s1 - s0) : t0;
      g = clip(g, 0, 65536);
      sl = slope_x(g);
      if (sl >= 66) begin
         for (int i = 0; i < NEWTON_STEPS; i++) begin
            s = slope_x(g);
            if (s == 0) break;
            r = curve_at(g, p1x, p2x) - x;
            g = clip(g - (r * 65536) / s, 0, 65536);
         end
         return g;
      end
      if (sl == 0) return g;
      // shallow or negative slope: bisect the table interval
      lo = t0;
      hi = t1;
      mid = t0;
      for (int i = 0; i < BISECT_STEPS; i++) begin
         mid = lo + ((hi - lo) >>> 1);
         r = curve_at(mid, p1x, p2x) - x;
         if (r > 0) hi = mid;
         else lo = mid;
         if (r == 0) break;
      end
      return mid;
   endfunction

   function automatic logic [Y_W-1:0] ease(logic [X_W-1:0] raw);
      longint x, y;
      x = longint'($signed(raw));
      if (is_linear) y = x;
      else if (x <= 0) y = 0;
      else if (x >= 65536) y = 65536;
      else y = curve_at(find_t(x), p1y, p2y);
      y = clip(y, -524288, 524287);
      return y[Y_W-1:0];
   endfunction

   function automatic void queue_value(logic [X_W-1:0] v);
      progress_q.push_back(v);
      n_queued++;
   endfunction

   // ---------------------------------------------------------------------
   // clock and reset
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // driver: changes inputs on the falling edge, holds a transaction until
   // the monitor has seen it accepted
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_taken  = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (progress_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {{(REQ_TDATA_W - X_W){1'b0}}, progress_q.pop_front()};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off counted down here
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // monitor: samples both channels on the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            eased_q.push_back(ease(req_tdata[X_W-1:0]));
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (eased_q.size() == 0) begin
               $error("unexpected eased_value transaction: actual %h", rsp_tdata[Y_W-1:0]);
               n_errors++;
            end else begin
               logic [Y_W-1:0] want;
               want = eased_q.pop_front();
               if (rsp_tdata[Y_W-1:0] !== want) begin
                  $error("eased_value mismatch: expected %h actual %h",
                         want, rsp_tdata[Y_W-1:0]);
                  n_errors++;
               end
               n_eased++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      apply_csr(idx, v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      n_configs++;
   endtask

   task automatic set_points(int x1, int y1, int x2, int y2);
      write_csr(CSR_CTRL1_X, CSR_DATA_W'(x1));
      write_csr(CSR_CTRL1_Y, CSR_DATA_W'(y1));
      write_csr(CSR_CTRL2_X, CSR_DATA_W'(x2));
      write_csr(CSR_CTRL2_Y, CSR_DATA_W'(y2));
   endtask

   // mostly inside the nominal range, some anywhere in the field
   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 8) queue_value(X_W'($urandom_range(0, 65536)));
         else queue_value(X_W'($urandom()));
      end
   endtask

   // every queued transaction has come back
   task automatic drain();
      wait (n_eased == n_queued);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_idle(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 75; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 75; end
         default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      n_errors = 0;
      n_eased = 0;
      n_queued = 0;
      n_configs = 0;
      hold_cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      p1x = 0; p1y = 0; p2x = 65536; p2y = 65536;
      refresh_curve();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset setting is the linear case, extremes pass straight through
      queue_value(18'h20000);
      queue_value(18'h1FFFF);
      queue_value(18'h0);
      queue_value(18'h1);
      queue_value(18'h3FFFF);
      queue_value(18'h10000);
      drain();
      // ease-in-out, then the edges of the curve domain
      set_points(27525, 0, 38011, 65536);
      queue_value(18'h20000);
      queue_value(18'h1FFFF);
      queue_value(18'h0);
      queue_value(18'h1);
      queue_value(18'hFFFF);
      queue_value(18'h10000);
      queue_value(18'h10001);
      queue_value(18'h3FFFF);
      queue_value(18'h8000);
      queue_value(18'h1999);
      drain();
      // both x at one: slope vanishes near the top, so bisection and zero slope
      set_points(65536, 524287, 65536, -524288);
      queue_value(18'hFFFF);
      queue_value(18'hFFF0);
      queue_value(18'hFF00);
      queue_value(18'hF000);
      queue_value(18'h0010);
      drain();

      // random phases over a spread of settings, idle pattern rotating
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: set_points(20'hFFFFF, -524288, 0, 524287);       // x over range clips
            1: set_points(0, 0, 0, 0);                          // all at zero, linear by equality
            2: set_points(65536, 65536, 65536, 65536);          // linear by equality
            3: set_points(16384, 16384, 49152, 49152);          // linear off-corner
            4: set_points(0, 524287, 65536, -524288);
            5: set_points(65536, -524288, 0, 524287);
            default: set_points($urandom_range(0, 65536), $urandom_range(0, 20'hFFFFF),
                                $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF));
         endcase
         set_idle(ph % 4);
         if (ph == 5) begin
            // long receiver hold-off while the sender keeps offering
            @(negedge clock);
            hold_cycles = 600;
         end
         queue_random(90);
         drain();
      end

      repeat (20) @(negedge clock);
      $display("covered %0d eased values over %0d register writes", n_eased, n_configs);
      $display("linear, clipped, newton and bisection paths under four idle patterns");
      if (n_errors == 0) begin
         $display("[cubic_bezier_easing] OK");
      end else begin
         $display("[cubic_bezier_easing] ERROR");
      end
      $finish;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #40ms;
      $display("[cubic_bezier_easing] ERROR");
      $finish;
   end

endmodule

### files.f
rtl/cbe_pkg.sv
rtl/cubic_bezier_easing.sv
bench/cubic_bezier_easing_tb.sv
